// ----- design/smdd_pkg.sv -----
package smdd_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    typedef enum logic [1:0] {
        FUNC_POLL  = 2'd0,
        FUNC_HUB   = 2'd1,
        FUNC_START = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_UNKNOWN   = 2'd0,
        MODE_MOMENTARY = 2'd1,
        MODE_LATCHING  = 2'd2,
        MODE_RESERVED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LATCH_DETECT = 2'd1,
        REG_DECOMMISSION = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] now_ms;
        logic              switch_closed;
        logic              decommission_pressed;
        logic              hub_value;
    } sample_t;

    typedef struct packed {
        logic       led_level;
        logic       on_off;
        logic [1:0] switch_mode;
        logic       forced_off_publish;
        logic       publish_valid;
        logic       publish_value;
        logic       reset_request;
    } result_t;

    typedef struct packed {
        logic [1:0]       index;
        logic [CFG_W-1:0] value;
    } cfg_write_t;

    // True once the wrapping interval from start to now reaches limit.
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] start,
                                     input logic [CFG_W-1:0]  limit);
        logic [TIME_W-1:0] span;
        span = now - start;
        return span >= {{(TIME_W-CFG_W){1'b0}}, limit};
    endfunction

endpackage

// ----- design/smdd_if.sv -----
interface smdd_sample_if;
    logic              valid;
    logic              ready;
    smdd_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smdd_result_if;
    logic              valid;
    logic              ready;
    smdd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smdd_cfg_if;
    logic                 valid;
    logic                 ready;
    smdd_pkg::cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/switch_mode_detect_debounce_top.sv -----
// Switch mode detector: time debounce, momentary/latching learning, decommission long hold.
// An accepted sample beat passes through the input register, then the result register,
// to its result beat. Throughput: one item per cycle while result.ready holds, set by the
// state update between the input register and the result register.
// Reset (rst_n low, asynchronous): all switch state cleared, registers back to
// debounce 50 ms, latch detect 1000 ms, decommission hold 5000 ms; both stages empty.
module switch_mode_detect_debounce_top (
    input  logic          clk,
    input  logic          rst_n,
    smdd_sample_if.sink   sample,
    smdd_result_if.source result,
    smdd_cfg_if.sink      cfg
);

    // Configuration registers
    logic [smdd_pkg::CFG_W-1:0] debounce_reg;
    logic [smdd_pkg::CFG_W-1:0] latch_detect_reg;
    logic [smdd_pkg::CFG_W-1:0] decommission_reg;

    // Pipeline registers
    logic              stage_valid_reg;
    smdd_pkg::sample_t stage_reg;
    logic              out_valid_reg;
    smdd_pkg::result_t out_reg;

    // Switch state
    smdd_pkg::mode_t             mode_reg,        mode_next;
    logic                        logical_on_reg,  logical_on_next;
    logic                        led_drive_reg,   led_drive_next;
    logic                        raw_level_reg,   raw_level_next;
    logic                        stable_reg,      stable_next;
    logic [smdd_pkg::TIME_W-1:0] change_time_reg, change_time_next;
    logic                        press_active_reg, press_active_next;
    logic [smdd_pkg::TIME_W-1:0] press_start_reg, press_start_next;
    logic                        last_latch_reg,  last_latch_next;
    logic                        hold_active_reg, hold_active_next;
    logic [smdd_pkg::TIME_W-1:0] hold_start_reg,  hold_start_next;
    logic                        hold_fired_reg,  hold_fired_next;
    smdd_pkg::result_t           res_next;

    logic advance;
    logic take_sample;

    // Advance the stage whenever the result register is empty or being drained;
    // accept a new sample beat whenever the stage is empty or advancing.
    assign advance      = stage_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !stage_valid_reg || advance;
    assign take_sample  = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Item processing: a poll runs the decommission detector, then debounce, then the mode handler.
    always_comb
    begin
        logic pub_v;
        logic pub_d;
        logic forced;
        logic rst_req;
        logic [smdd_pkg::TIME_W-1:0] now;

        now     = stage_reg.now_ms;
        pub_v   = 1'b0;
        pub_d   = 1'b0;
        forced  = 1'b0;
        rst_req = 1'b0;

        mode_next         = mode_reg;
        logical_on_next   = logical_on_reg;
        led_drive_next    = led_drive_reg;
        raw_level_next    = raw_level_reg;
        stable_next       = stable_reg;
        change_time_next  = change_time_reg;
        press_active_next = press_active_reg;
        press_start_next  = press_start_reg;
        last_latch_next   = last_latch_reg;
        hold_active_next  = hold_active_reg;
        hold_start_next   = hold_start_reg;
        hold_fired_next   = hold_fired_reg;

        case (smdd_pkg::func_t'(stage_reg.func))
            smdd_pkg::FUNC_POLL:
            begin
                // Decommission long hold: fire once per press.
                if (stage_reg.decommission_pressed)
                begin
                    if (!hold_active_reg)
                    begin
                        hold_active_next = 1'b1;
                        hold_start_next  = now;
                        hold_fired_next  = 1'b0;
                    end
                    else if (!hold_fired_reg &&
                             smdd_pkg::reached(now, hold_start_reg, decommission_reg))
                    begin
                        hold_fired_next = 1'b1;
                        led_drive_next  = 1'b0;
                        logical_on_next = 1'b0;
                        forced          = 1'b1;
                        rst_req         = 1'b1;
                    end
                end
                else
                begin
                    hold_active_next = 1'b0;
                end

                // Debounce: a level change only restarts the timer.
                if (stage_reg.switch_closed != raw_level_reg)
                begin
                    raw_level_next   = stage_reg.switch_closed;
                    change_time_next = now;
                end
                else if (smdd_pkg::reached(now, change_time_reg, debounce_reg))
                begin
                    stable_next = stage_reg.switch_closed;
                end

                case (mode_reg)
                    smdd_pkg::MODE_UNKNOWN:
                    begin
                        if (stable_next)
                        begin
                            if (!press_active_reg)
                            begin
                                press_active_next = 1'b1;
                                press_start_next  = now;
                            end
                            else if (smdd_pkg::reached(now, press_start_reg,
                                                       latch_detect_reg))
                            begin
                                // Long hold: latching, follow the position.
                                press_active_next = 1'b0;
                                mode_next         = smdd_pkg::MODE_LATCHING;
                                last_latch_next   = 1'b1;
                                led_drive_next    = 1'b1;
                                logical_on_next   = 1'b1;
                                pub_v             = 1'b1;
                                pub_d             = 1'b1;
                            end
                        end
                        else if (press_active_reg)
                        begin
                            press_active_next = 1'b0;
                            if (smdd_pkg::reached(now, press_start_reg, debounce_reg))
                            begin
                                mode_next       = smdd_pkg::MODE_MOMENTARY;
                                pub_d           = !logical_on_next;
                                led_drive_next  = pub_d;
                                logical_on_next = pub_d;
                                pub_v           = 1'b1;
                            end
                        end
                    end
                    smdd_pkg::MODE_MOMENTARY:
                    begin
                        if (stable_next)
                        begin
                            if (!press_active_reg)
                            begin
                                press_active_next = 1'b1;
                                press_start_next  = now;
                            end
                        end
                        else if (press_active_reg &&
                                 smdd_pkg::reached(now, press_start_reg, debounce_reg))
                        begin
                            // Toggle on release.
                            press_active_next = 1'b0;
                            pub_d             = !logical_on_next;
                            led_drive_next    = pub_d;
                            logical_on_next   = pub_d;
                            pub_v             = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stable_next != last_latch_reg)
                        begin
                            last_latch_next = stable_next;
                            led_drive_next  = stable_next;
                            logical_on_next = stable_next;
                            pub_v           = 1'b1;
                            pub_d           = stable_next;
                        end
                    end
                endcase
            end
            smdd_pkg::FUNC_HUB:
            begin
                logical_on_next = stage_reg.hub_value;
                led_drive_next  = stage_reg.hub_value;
            end
            smdd_pkg::FUNC_START:
            begin
                raw_level_next   = stage_reg.switch_closed;
                stable_next      = stage_reg.switch_closed;
                change_time_next = now;
                logical_on_next  = stage_reg.switch_closed;
                led_drive_next   = stage_reg.switch_closed;
                if (stage_reg.switch_closed)
                begin
                    press_active_next = 1'b1;
                    press_start_next  = now;
                end
            end
            default:
            begin
                // Unused code: hold all state.
            end
        endcase

        res_next.led_level          = led_drive_next;
        res_next.on_off             = logical_on_next;
        res_next.switch_mode        = mode_next;
        res_next.forced_off_publish = forced;
        res_next.publish_valid      = pub_v;
        res_next.publish_value      = pub_v && pub_d;
        res_next.reset_request      = rst_req;
    end

    // Configuration writes; drop writes to indexes beyond the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= smdd_pkg::CFG_W'(50);
            latch_detect_reg <= smdd_pkg::CFG_W'(1000);
            decommission_reg <= smdd_pkg::CFG_W'(5000);
        end
        else if (cfg.valid)
        begin
            case (smdd_pkg::reg_index_t'(cfg.data.index))
                smdd_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg.data.value;
                smdd_pkg::REG_LATCH_DETECT: latch_detect_reg <= cfg.data.value;
                smdd_pkg::REG_DECOMMISSION: decommission_reg <= cfg.data.value;
                default:
                begin
                end
            endcase
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            stage_valid_reg <= sample.valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            stage_reg <= sample.data;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    // Switch state: commit when the stage advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= smdd_pkg::MODE_UNKNOWN;
            logical_on_reg   <= 1'b0;
            led_drive_reg    <= 1'b0;
            raw_level_reg    <= 1'b0;
            stable_reg       <= 1'b0;
            change_time_reg  <= '0;
            press_active_reg <= 1'b0;
            press_start_reg  <= '0;
            last_latch_reg   <= 1'b0;
            hold_active_reg  <= 1'b0;
            hold_start_reg   <= '0;
            hold_fired_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            logical_on_reg   <= logical_on_next;
            led_drive_reg    <= led_drive_next;
            raw_level_reg    <= raw_level_next;
            stable_reg       <= stable_next;
            change_time_reg  <= change_time_next;
            press_active_reg <= press_active_next;
            press_start_reg  <= press_start_next;
            last_latch_reg   <= last_latch_next;
            hold_active_reg  <= hold_active_next;
            hold_start_reg   <= hold_start_next;
            hold_fired_reg   <= hold_fired_next;
        end
    end

endmodule
